>>> rtl/bcde_pkg.sv
// shared types and constants for the block copy dma engine
package bcde_pkg;

    // default widths
    localparam int ADDR_BITS_DEF = 16;
    localparam int DATA_BITS_DEF = 32;

    // engine phases
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HOLD = 2'd1,
        PH_COPY = 2'd2,
        PH_READ = 2'd3
    } phase_t;

    // per-tick memory strobes and status from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic busy;
    } ctrl_flags_t;

endpackage

>>> rtl/bcde_if.sv
// valid/ready channel interfaces for tick items and per-tick results

interface bcde_item_if
    import bcde_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [ADDR_BITS-1:0] src_addr;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [ADDR_BITS-1:0] length;
    logic                 mem_blocked;
    logic [DATA_BITS-1:0] read_data;

    modport source (
        output valid, cmd, src_addr, dst_addr, length, mem_blocked, read_data,
        input  ready
    );
    modport sink (
        input  valid, cmd, src_addr, dst_addr, length, mem_blocked, read_data,
        output ready
    );
endinterface

interface bcde_result_if
    import bcde_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [DATA_BITS-1:0] wr_data;
    logic                 busy_res;

    modport source (
        output valid, rd_en, rd_addr, wr_en, wr_addr, wr_data, busy_res,
        input  ready
    );
    modport sink (
        input  valid, rd_en, rd_addr, wr_en, wr_addr, wr_data, busy_res,
        output ready
    );
endinterface

>>> rtl/block_copy_dma_engine_unit.sv
// Block copy DMA engine top level.
// Channels: item (sink) carries one clock tick of the copy engine: a start
// command with source, destination and length, the processor memory-hold flag
// and the word read back for the previous tick. result (source) carries the
// tick's read strobe and address, write strobe, address and data, and busy.
// Every accepted item gives exactly one result, in order.
// The result is registered and shows in the cycle after the item is accepted.
// Throughput: one item per cycle when not stalled; the single output register
// is the only storage on the path and is refilled in the cycle it is emptied.
// Stall: while a result waits and result.ready is low, item.ready is low and
// the sequencer state holds; no tick is lost or repeated.
// Reset: rst_n clears the phase, counters and the output valid bit; the
// engine starts idle with busy low.
// A copy of N words takes one tick to start, then per word one read tick and
// one write tick, plus every tick spent on hold (at least one after the start,
// and at least one after each write but the last that sees the memory held).
module block_copy_dma_engine_unit
    import bcde_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    bcde_item_if.sink      item,
    bcde_result_if.source  result
);

    logic                 step;
    ctrl_flags_t          flags;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [DATA_BITS-1:0] wr_data;

    logic                 valid_reg;
    ctrl_flags_t          flags_reg;
    logic [ADDR_BITS-1:0] rd_addr_reg;
    logic [ADDR_BITS-1:0] wr_addr_reg;
    logic [DATA_BITS-1:0] wr_data_reg;

    // take a tick whenever the output register is free or being drained
    assign item.ready = !valid_reg || result.ready;
    assign step       = item.valid && item.ready;

    // sequencer
    bcde_ctrl #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .cmd         (item.cmd),
        .src_addr    (item.src_addr),
        .dst_addr    (item.dst_addr),
        .length      (item.length),
        .mem_blocked (item.mem_blocked),
        .read_data   (item.read_data),
        .flags       (flags),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    // output payload, loaded on each accepted transfer
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            flags_reg   <= flags;
            rd_addr_reg <= rd_addr;
            wr_addr_reg <= wr_addr;
            wr_data_reg <= wr_data;
        end
    end

    assign result.valid    = valid_reg;
    assign result.rd_en    = flags_reg.rd_en;
    assign result.rd_addr  = rd_addr_reg;
    assign result.wr_en    = flags_reg.wr_en;
    assign result.wr_addr  = wr_addr_reg;
    assign result.wr_data  = wr_data_reg;
    assign result.busy_res = flags_reg.busy;

endmodule

>>> rtl/bcde_ctrl.sv
// copy sequencer: phase register, address and word counters, per-tick strobes
module bcde_ctrl
    import bcde_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 cmd,
    input  logic [ADDR_BITS-1:0] src_addr,
    input  logic [ADDR_BITS-1:0] dst_addr,
    input  logic [ADDR_BITS-1:0] length,
    input  logic                 mem_blocked,
    input  logic [DATA_BITS-1:0] read_data,
    output ctrl_flags_t          flags,
    output logic [ADDR_BITS-1:0] rd_addr,
    output logic [ADDR_BITS-1:0] wr_addr,
    output logic [DATA_BITS-1:0] wr_data
);

    phase_t               phase_reg, phase_next;
    logic [ADDR_BITS-1:0] src_reg, src_next;
    logic [ADDR_BITS-1:0] dst_reg, dst_next;
    logic [ADDR_BITS-1:0] total_reg, total_next;
    logic [ADDR_BITS-1:0] done_reg, done_next;
    logic [ADDR_BITS-1:0] done_inc;

    // state registers, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            src_reg   <= '0;
            dst_reg   <= '0;
            total_reg <= '0;
            done_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    assign done_inc = done_reg + 1'b1;

    // next state and memory strobes for the current tick
    always_comb
    begin
        phase_next = phase_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        total_next = total_reg;
        done_next  = done_reg;
        flags      = '0;
        rd_addr    = '0;
        wr_addr    = '0;
        wr_data    = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                // start latches operands; zero length stays idle
                if (cmd)
                begin
                    src_next   = src_addr;
                    dst_next   = dst_addr;
                    total_next = length;
                    done_next  = '0;
                    if (length != '0)
                    begin
                        phase_next = PH_HOLD;
                    end
                end
            end
            PH_HOLD:
            begin
                phase_next = mem_blocked ? PH_HOLD : PH_READ;
            end
            PH_READ:
            begin
                flags.rd_en = 1'b1;
                rd_addr     = src_reg;
                phase_next  = PH_COPY;
            end
            PH_COPY:
            begin
                flags.wr_en = 1'b1;
                wr_addr     = dst_reg;
                wr_data     = read_data;
                src_next    = src_reg + 1'b1;
                dst_next    = dst_reg + 1'b1;
                if (done_inc == total_reg)
                begin
                    done_next  = '0;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    done_next  = done_inc;
                    phase_next = mem_blocked ? PH_HOLD : PH_READ;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        // busy reflects the phase after this tick
        flags.busy = (phase_next != PH_IDLE);
    end

`ifndef SYNTHESIS
    // a read tick is always followed by the matching write tick
    a_read_then_copy: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_READ |=> phase_reg == PH_COPY)
        else $error("read phase not followed by copy phase");

    // state only moves on an accepted tick
    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(done_reg) && $stable(src_reg))
        else $error("sequencer state changed without a tick");

    // word count is cleared whenever the engine is idle
    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> done_reg == '0)
        else $error("word count nonzero while idle");

    // a start with zero length never leaves idle
    a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_IDLE && length == '0 |=> phase_reg == PH_IDLE)
        else $error("zero length start left idle");
`endif

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the block copy dma engine top level
`timescale 1ns / 100ps

module tb_top;
    import bcde_pkg::*;

    localparam int AW          = ADDR_BITS_DEF;
    localparam int DW          = DATA_BITS_DEF;
    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int COPY_TICKS  = 1400;
    localparam int LONG_COPY   = 250;
    localparam int MAX_REPORTS = 10;

    // one engine tick as offered on the item channel
    typedef struct {
        logic          cmd;
        logic [AW-1:0] src;
        logic [AW-1:0] dst;
        logic [AW-1:0] len;
        logic          blocked;
        logic [DW-1:0] rdata;
    } tick_t;

    // memory strobes and status produced by one tick
    typedef struct {
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [DW-1:0] wr_data;
        logic          busy;
    } strobe_t;

    logic clk = 1'b0;
    logic rst_n;

    bcde_item_if   #(.ADDR_BITS(AW), .DATA_BITS(DW)) item_ch ();
    bcde_result_if #(.ADDR_BITS(AW), .DATA_BITS(DW)) strobe_ch ();

    block_copy_dma_engine_unit #(
        .ADDR_BITS(AW),
        .DATA_BITS(DW)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (strobe_ch)
    );

    // copy engine shadow state
    phase_t        eng_phase;
    logic [AW-1:0] eng_src;
    logic [AW-1:0] eng_dst;
    logic [AW-1:0] eng_total;
    logic [AW-1:0] eng_done;
    logic          eng_busy;

    strobe_t strobe_q[$];
    int      fail_count    = 0;
    int      idle_cycles   = 0;
    bit      sender_steady = 1'b0;
    bit      sink_steady   = 1'b0;
    bit      long_hold_req = 1'b0;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(3, 1);
        else if (roll < 98)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // advance the shadow engine by one tick and return its strobes
    function automatic strobe_t advance_engine(tick_t t);
        strobe_t s;
        s.rd_en   = 1'b0;
        s.rd_addr = '0;
        s.wr_en   = 1'b0;
        s.wr_addr = '0;
        s.wr_data = '0;
        case (eng_phase)
            PH_IDLE:
            begin
                // start is only honored while idle; zero length never leaves idle
                if (t.cmd && !eng_busy)
                begin
                    eng_src   = t.src;
                    eng_dst   = t.dst;
                    eng_total = t.len;
                    eng_done  = '0;
                    if (t.len != '0)
                    begin
                        eng_busy  = 1'b1;
                        eng_phase = PH_HOLD;
                    end
                end
            end
            PH_HOLD:
                eng_phase = t.blocked ? PH_HOLD : PH_READ;
            PH_READ:
            begin
                s.rd_en   = 1'b1;
                s.rd_addr = eng_src;
                eng_phase = PH_COPY;
            end
            default:
            begin
                // write back the returned word, step pointers and count
                s.wr_en   = 1'b1;
                s.wr_addr = eng_dst;
                s.wr_data = t.rdata;
                eng_done  = eng_done + 1'b1;
                eng_src   = eng_src + 1'b1;
                eng_dst   = eng_dst + 1'b1;
                if (eng_done == eng_total)
                begin
                    eng_busy  = 1'b0;
                    eng_done  = '0;
                    eng_phase = PH_IDLE;
                end
                else
                begin
                    eng_phase = t.blocked ? PH_HOLD : PH_READ;
                end
            end
        endcase
        s.busy = eng_busy;
        return s;
    endfunction

    function automatic tick_t random_tick(int start_pct, int block_pct);
        tick_t t;
        t.cmd     = ($urandom_range(99) < start_pct);
        t.src     = AW'($urandom);
        t.dst     = AW'($urandom);
        t.len     = AW'($urandom);
        t.blocked = ($urandom_range(99) < block_pct);
        t.rdata   = DW'($urandom);
        return t;
    endfunction

    // start command, sometimes placed just below the address wrap
    function automatic tick_t copy_start(logic [AW-1:0] words);
        tick_t t;
        t = random_tick(100, 30);
        if ($urandom_range(3) == 0)
            t.src = '1 - AW'($urandom_range(7));
        if ($urandom_range(3) == 0)
            t.dst = '1 - AW'($urandom_range(7));
        t.len = words;
        return t;
    endfunction

    function automatic logic [AW-1:0] pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        else if (roll < 75)
            return AW'($urandom_range(8, 1));
        else if (roll < 95)
            return AW'($urandom_range(40, 9));
        else
            return AW'($urandom_range(300, 41));
    endfunction

    // offer one tick and wait for the transfer
    task automatic send_tick(input tick_t t);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= t.cmd;
        item_ch.src_addr    <= t.src;
        item_ch.dst_addr    <= t.dst;
        item_ch.length      <= t.len;
        item_ch.mem_blocked <= t.blocked;
        item_ch.read_data   <= t.rdata;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // keep ticking until the shadow engine is idle again
    task automatic run_until_idle(input int start_pct, input int block_pct, inout int ticks);
        while (eng_phase != PH_IDLE)
        begin
            send_tick(random_tick(start_pct, block_pct));
            ticks++;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    // predict on each accepted tick
    always @(posedge clk)
    begin
        tick_t t;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            t.cmd     = item_ch.cmd;
            t.src     = item_ch.src_addr;
            t.dst     = item_ch.dst_addr;
            t.len     = item_ch.length;
            t.blocked = item_ch.mem_blocked;
            t.rdata   = item_ch.read_data;
            strobe_q.push_back(advance_engine(t));
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        strobe_t want;
        if (rst_n && strobe_ch.valid && strobe_ch.ready)
        begin
            if (strobe_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result transfer with no prediction pending");
            end
            else
            begin
                want = strobe_q.pop_front();
                check_field("rd_en", 64'(want.rd_en), 64'(strobe_ch.rd_en));
                check_field("rd_addr", 64'(want.rd_addr), 64'(strobe_ch.rd_addr));
                check_field("wr_en", 64'(want.wr_en), 64'(strobe_ch.wr_en));
                check_field("wr_addr", 64'(want.wr_addr), 64'(strobe_ch.wr_addr));
                check_field("wr_data", 64'(want.wr_data), 64'(strobe_ch.wr_data));
                check_field("busy_res", 64'(want.busy), 64'(strobe_ch.busy_res));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (strobe_ch.valid && strobe_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // result receiver with random stalls and an occasional long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        strobe_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                strobe_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                strobe_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                strobe_ch.ready <= 1'b1;
                if (!sink_steady)
                    stall_left = pick_gap();
            end
        end
    end

    // ticks while idle do nothing, whatever the operand fields hold
    task automatic test_idle_ticks();
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b0, '0});
        send_tick(tick_t'{1'b0, '1, '1, '1, 1'b1, '1});
    endtask

    // zero length is taken but never raises busy
    task automatic test_zero_length();
        send_tick(tick_t'{1'b1, '1, '1, '0, 1'b0, '1});
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b0, '0});
    endtask

    // one word with memory held, blocking ignored in read and on the last write
    task automatic test_single_word_with_hold();
        send_tick(tick_t'{1'b1, '1, '0, AW'(1), 1'b0, '0});
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b1, '0});
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b0, '0});
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b1, '0});
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b1, '1});
    endtask

    // restart ignored while busy, pointers wrap past the top address
    task automatic test_start_while_busy_and_wrap();
        send_tick(tick_t'{1'b1, '1, '1, AW'(2), 1'b0, '0});
        send_tick(tick_t'{1'b1, AW'(16'h1234), AW'(16'h4321), AW'(5), 1'b0, '0});
        send_tick(tick_t'{1'b1, '0, '0, AW'(7), 1'b1, '0});
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b1, '0});
        send_tick(tick_t'{1'b1, '1, '1, '1, 1'b0, '1});
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b0, '0});
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b0, DW'(32'hA5A5_A5A5)});
        send_tick(tick_t'{1'b0, '0, '0, '0, 1'b0, DW'(32'h5A5A_5A5A)});
    endtask

    // receiver holds off while ticks keep coming so the input stalls
    task automatic test_pressure_stall();
        int ticks;
        ticks = 0;
        sender_steady = 1'b1;
        long_hold_req = 1'b1;
        send_tick(copy_start(AW'(24)));
        run_until_idle(20, 10, ticks);
        sender_steady = 1'b0;
    endtask

    // one long copy, back to back
    task automatic test_max_length();
        tick_t t;
        int    ticks;
        ticks = 0;
        sender_steady = 1'b1;
        sink_steady = 1'b1;
        t = copy_start(AW'(LONG_COPY));
        send_tick(t);
        run_until_idle(10, 5, ticks);
        sender_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // random copies with random holds, mixed with idle noise
    task automatic test_random_copies();
        int ticks;
        int block_pct;
        int roll;
        ticks = 0;
        while (ticks < COPY_TICKS)
        begin
            roll = $urandom_range(99);
            if (roll < 12)
            begin
                repeat ($urandom_range(3, 1))
                    send_tick(random_tick(0, 50));
            end
            else
            begin
                sender_steady = ($urandom_range(3) == 0);
                sink_steady = sender_steady;
                case ($urandom_range(2))
                    0: block_pct = 0;
                    1: block_pct = 30;
                    default: block_pct = 70;
                endcase
                send_tick(copy_start(pick_length()));
                ticks++;
                run_until_idle(20, block_pct, ticks);
            end
        end
        sender_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.cmd         = 1'b0;
        item_ch.src_addr    = '0;
        item_ch.dst_addr    = '0;
        item_ch.length      = '0;
        item_ch.mem_blocked = 1'b0;
        item_ch.read_data   = '0;
        eng_phase = PH_IDLE;
        eng_src   = '0;
        eng_dst   = '0;
        eng_total = '0;
        eng_done  = '0;
        eng_busy  = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_ticks();
        test_zero_length();
        test_single_word_with_hold();
        test_start_while_busy_and_wrap();
        test_pressure_stall();
        test_random_copies();
        test_max_length();

        // drain outstanding results
        item_ch.valid <= 1'b0;
        while (strobe_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
